/* src/xrg_pkg.sv */
package xrg_pkg;

	localparam int WORD_W = 64;

	// splitmix64 and xoshiro256** constants
	localparam logic [WORD_W-1:0] SEED_RESET  = 64'hdeadbeefdeadbeef;
	localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
	localparam int SHIFT_T   = 17;
	localparam int ROT_S3    = 45;
	localparam int ROT_OUT   = 7;

	// request modes
	localparam logic [1:0] MODE_RAW  = 2'd0;
	localparam logic [1:0] MODE_TOP  = 2'd1;
	localparam logic [1:0] MODE_INCL = 2'd2;
	localparam logic [1:0] MODE_EXCL = 2'd3;

	// partial-product phases of the 64x64 (low half) multiply
	localparam logic [1:0] MUL_LO     = 2'd0;
	localparam logic [1:0] MUL_CROSS1 = 2'd1;
	localparam logic [1:0] MUL_CROSS2 = 2'd2;

	// result source select
	localparam logic [1:0] RES_BAD = 2'd0;
	localparam logic [1:0] RES_LOW = 2'd1;
	localparam logic [1:0] RES_RAW = 2'd2;
	localparam logic [1:0] RES_SUM = 2'd3;

	typedef struct packed {
		logic       acc_load;
		logic       seed_add;
		logic       mul_en;
		logic [1:0] mul_phase;
		logic       mul_sel_b;
		logic       mix27;
		logic       word_we;
		logic [1:0] word_idx;
		logic       req_load;
		logic       check;
		logic       thr_start;
		logic       limit_load;
		logic       draw;
		logic       mod_start;
		logic [1:0] res_sel;
		logic       out_load;
	} xrg_cmd_t;

	typedef struct packed {
		logic range_req;
		logic bad;
		logic n_one;
		logic n_zero;
		logic reject;
		logic rem_busy;
		logic rem_done;
	} xrg_stat_t;

endpackage

/* src/xoshiro256ss_range_generator_core.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: bit_count, low_bound, high_bound; tuser: mode
// m_*       out  m_tvalid/m_tready  tdata: value; tuser: bad_request
// APB       in   psel/penable       seed at byte address 0 (64-bit data)
//
// Raw and top-bit requests pass through the check, draw and output states from
// accept to result. Range requests redraw on every rejected value; the
// bit-serial remainder unit (64 steps, run twice) takes most of their time.
// Reset and every seed write run a splitmix64 expansion through
// the shared 32x32 multiplier; no request is taken until it finishes.
// The next request is taken while a result waits in the output register.
module xoshiro256ss_range_generator_core
	import xrg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// request: [6:0] bit_count, [70:7] low_bound, [134:71] high_bound, [135] zero
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [63:0] value
	output logic [63:0]  m_tdata,
	// [0] bad_request
	output logic [0:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [WORD_W-1:0] seed_q;
	logic              cfg_we;
	logic              bad_request;
	xrg_cmd_t          cmd;
	xrg_stat_t         stat;

	// APB: zero wait states, seed is the only register
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[3] == 1'b0);
	assign prdata = (paddr[3] == 1'b0) ? seed_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= SEED_RESET;
		else if (cfg_we)
			seed_q <= pwdata;
	end

	// sequence seeding, draws, rejection loop and result hand-off
	xrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// generator state, multiplier, remainder unit and output register
	xrg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed        (seed_q),
		.mode        (s_tuser),
		.bit_count   (s_tdata[6:0]),
		.low_bound   (s_tdata[70:7]),
		.high_bound  (s_tdata[134:71]),
		.cmd         (cmd),
		.stat        (stat),
		.value       (m_tdata),
		.bad_request (bad_request)
	);

	assign m_tuser[0] = bad_request;

	// a bad request carries a zero value
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
		else $error("bad request with nonzero value");

	// never restart the remainder unit while it is stepping
	a_rem_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.thr_start || cmd.mod_start |-> !stat.rem_busy)
		else $error("remainder unit restarted while busy");

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// a seed write blocks requests until the expansion finishes
	a_seed_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("request taken during seed expansion");

endmodule

/* src/xrg_rem.sv */
module xrg_rem
	import xrg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic [WORD_W-1:0] rem,
	output logic              busy,
	output logic              done
);

	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] d_q;
	logic [WORD_W-1:0] r_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;
	logic [WORD_W-1:0] r_next;

	// one restoring step: shift in the next dividend bit, subtract when it fits
	always_comb begin
		trial  = {r_q, x_q[WORD_W-1]};
		diff   = trial - {1'b0, d_q};
		r_next = (trial >= {1'b0, d_q}) ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'd63;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[WORD_W-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign rem  = r_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

/* src/xrg_dp.sv */
module xrg_dp
	import xrg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] seed,
	input  logic [1:0]        mode,
	input  logic [6:0]        bit_count,
	input  logic [WORD_W-1:0] low_bound,
	input  logic [WORD_W-1:0] high_bound,
	input  xrg_cmd_t          cmd,
	output xrg_stat_t         stat,
	output logic [WORD_W-1:0] value,
	output logic              bad_request
);

	logic [WORD_W-1:0] words_q [4];
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] z_q;
	logic [WORD_W-1:0] prod_q;
	logic [1:0]        mode_q;
	logic [6:0]        bits_q;
	logic [WORD_W-1:0] lo_q;
	logic [WORD_W-1:0] hi_q;
	logic [WORD_W-1:0] n_q;
	logic              bad_q;
	logic [WORD_W-1:0] limit_q;
	logic [WORD_W-1:0] r_q;
	logic [WORD_W-1:0] value_q;
	logic              bad_out_q;

	logic [WORD_W-1:0] acc_n;
	logic [WORD_W-1:0] mconst;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       mul_p;
	logic [WORD_W-1:0] m5;
	logic [WORD_W-1:0] rot7;
	logic [WORD_W-1:0] draw_out;
	logic [WORD_W-1:0] s2a;
	logic [WORD_W-1:0] s3a;
	logic [6:0]        bsat;
	logic [6:0]        shamt;
	logic [WORD_W-1:0] raw_val;
	logic [WORD_W-1:0] res_val;
	logic              rem_start;
	logic [WORD_W-1:0] rem_dividend;
	logic [WORD_W-1:0] rem_out;
	logic              rem_busy;
	logic              rem_done;

	assign acc_n  = acc_q + GOLDEN_STEP;
	assign mconst = cmd.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;

	// one 32x32 product per cycle, low 64 bits accumulated over three phases
	always_comb begin
		case (cmd.mul_phase)
			MUL_LO: begin
				mul_a = z_q[31:0];
				mul_b = mconst[31:0];
			end
			MUL_CROSS1: begin
				mul_a = z_q[31:0];
				mul_b = mconst[63:32];
			end
			MUL_CROSS2: begin
				mul_a = z_q[63:32];
				mul_b = mconst[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// xoshiro256** output and next state
	always_comb begin
		m5       = words_q[1] + (words_q[1] << 2);
		rot7     = {m5[WORD_W-1-ROT_OUT:0], m5[WORD_W-1:WORD_W-ROT_OUT]};
		draw_out = rot7 + (rot7 << 3);
		s2a      = words_q[2] ^ words_q[0];
		s3a      = words_q[3] ^ words_q[1];
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_load)
			acc_q <= seed;
		if (cmd.seed_add) begin
			acc_q <= acc_n;
			z_q   <= acc_n ^ (acc_n >> 30);
		end
		if (cmd.mix27)
			z_q <= prod_q ^ (prod_q >> 27);
		if (cmd.mul_en) begin
			if (cmd.mul_phase == MUL_LO)
				prod_q <= mul_p;
			else
				prod_q <= prod_q + {mul_p[31:0], 32'd0};
		end
		if (cmd.word_we)
			words_q[cmd.word_idx] <= prod_q ^ (prod_q >> 31);
		if (cmd.draw) begin
			r_q        <= draw_out;
			words_q[0] <= words_q[0] ^ s3a;
			words_q[1] <= words_q[1] ^ s2a;
			words_q[2] <= s2a ^ (words_q[1] << SHIFT_T);
			words_q[3] <= {s3a[WORD_W-1-ROT_S3:0], s3a[WORD_W-1:WORD_W-ROT_S3]};
		end
	end

	// request capture and bound check
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			mode_q <= mode;
			bits_q <= bit_count;
			lo_q   <= low_bound;
			hi_q   <= high_bound;
		end
		if (cmd.check) begin
			n_q   <= hi_q - lo_q + {63'd0, mode_q == MODE_INCL};
			bad_q <= (lo_q > hi_q) || ((mode_q == MODE_EXCL) && (lo_q == hi_q));
		end
		if (cmd.limit_load)
			limit_q <= ~rem_out;
	end

	assign rem_start    = cmd.thr_start || cmd.mod_start;
	assign rem_dividend = cmd.thr_start ? (~n_q + 64'd1) : r_q;

	xrg_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dividend),
		.divisor  (n_q),
		.rem      (rem_out),
		.busy     (rem_busy),
		.done     (rem_done)
	);

	// result formation
	always_comb begin
		bsat    = (bits_q > 7'd64) ? 7'd64 : bits_q;
		shamt   = 7'd64 - bsat;
		raw_val = (mode_q == MODE_TOP) ? (r_q >> shamt) : r_q;
		case (cmd.res_sel)
			RES_BAD: res_val = '0;
			RES_LOW: res_val = lo_q;
			RES_RAW: res_val = raw_val;
			RES_SUM: res_val = lo_q + rem_out;
			default: res_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q   <= res_val;
			bad_out_q <= (cmd.res_sel == RES_BAD);
		end
	end

	assign stat.range_req = mode_q[1];
	assign stat.bad       = bad_q;
	assign stat.n_one     = (n_q == 64'd1);
	assign stat.n_zero    = (n_q == 64'd0);
	assign stat.reject    = (r_q > limit_q);
	assign stat.rem_busy  = rem_busy;
	assign stat.rem_done  = rem_done;

	assign value       = value_q;
	assign bad_request = bad_out_q;

endmodule

/* src/xrg_ctrl.sv */
module xrg_ctrl
	import xrg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  xrg_stat_t stat,
	output xrg_cmd_t  cmd
);

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_SEED_ADD = 4'd1;
	localparam logic [3:0] ST_MUL_A    = 4'd2;
	localparam logic [3:0] ST_MIX      = 4'd3;
	localparam logic [3:0] ST_MUL_B    = 4'd4;
	localparam logic [3:0] ST_STORE    = 4'd5;
	localparam logic [3:0] ST_IDLE     = 4'd6;
	localparam logic [3:0] ST_CHECK    = 4'd7;
	localparam logic [3:0] ST_SPAN     = 4'd8;
	localparam logic [3:0] ST_THR      = 4'd9;
	localparam logic [3:0] ST_DRAW_R   = 4'd10;
	localparam logic [3:0] ST_REJ      = 4'd11;
	localparam logic [3:0] ST_MOD      = 4'd12;
	localparam logic [3:0] ST_DRAW     = 4'd13;
	localparam logic [3:0] ST_OUT      = 4'd14;

	logic [3:0] state_q, state_d;
	logic [1:0] mcnt_q, mcnt_d;
	logic [1:0] widx_q, widx_d;
	logic [1:0] res_q, res_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && !cfg_we;

	always_comb begin
		state_d = state_q;
		mcnt_d  = mcnt_q;
		widx_d  = widx_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.mul_phase = mcnt_q;
		cmd.word_idx  = widx_q;
		cmd.res_sel   = res_q;
		case (state_q)
			ST_LOAD: begin
				cmd.acc_load = 1'b1;
				widx_d  = 2'd0;
				state_d = ST_SEED_ADD;
			end
			ST_SEED_ADD: begin
				cmd.seed_add = 1'b1;
				mcnt_d  = MUL_LO;
				state_d = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd.mul_en = 1'b1;
				if (mcnt_q == MUL_CROSS2) begin
					mcnt_d  = MUL_LO;
					state_d = ST_MIX;
				end else begin
					mcnt_d = mcnt_q + 2'd1;
				end
			end
			ST_MIX: begin
				cmd.mix27 = 1'b1;
				state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel_b = 1'b1;
				if (mcnt_q == MUL_CROSS2) begin
					mcnt_d  = MUL_LO;
					state_d = ST_STORE;
				end else begin
					mcnt_d = mcnt_q + 2'd1;
				end
			end
			ST_STORE: begin
				cmd.word_we = 1'b1;
				widx_d = widx_q + 2'd1;
				state_d = (widx_q == 2'd3) ? ST_IDLE : ST_SEED_ADD;
			end
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.req_load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (stat.range_req) begin
					state_d = ST_SPAN;
				end else begin
					state_d = ST_DRAW;
				end
			end
			ST_SPAN: begin
				if (stat.bad) begin
					res_d   = RES_BAD;
					state_d = ST_OUT;
				end else if (stat.n_one) begin
					res_d   = RES_LOW;
					state_d = ST_OUT;
				end else if (stat.n_zero) begin
					state_d = ST_DRAW;
				end else begin
					cmd.thr_start = 1'b1;
					state_d = ST_THR;
				end
			end
			ST_THR: begin
				if (stat.rem_done) begin
					cmd.limit_load = 1'b1;
					state_d = ST_DRAW_R;
				end
			end
			ST_DRAW_R: begin
				cmd.draw = 1'b1;
				state_d = ST_REJ;
			end
			ST_REJ: begin
				if (stat.reject) begin
					state_d = ST_DRAW_R;
				end else begin
					cmd.mod_start = 1'b1;
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (stat.rem_done) begin
					res_d   = RES_SUM;
					state_d = ST_OUT;
				end
			end
			ST_DRAW: begin
				cmd.draw = 1'b1;
				res_d   = RES_RAW;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
		// a seed write restarts the state expansion
		if (cfg_we)
			state_d = ST_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			mcnt_q      <= MUL_LO;
			widx_q      <= 2'd0;
			res_q       <= RES_BAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mcnt_q  <= mcnt_d;
			widx_q  <= widx_d;
			res_q   <= res_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
